// File: hdl/dcas_pkg.sv
// Shared types and constants for the debounced clock and alarm setter.
package dcas_pkg;

    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned MsW     = 16;

    localparam logic [MsW-1:0]     LOCKOUT_RESET = MsW'(500);
    localparam logic [HourW-1:0]   HOUR_LAST     = HourW'(23);
    localparam logic [MinuteW-1:0] MINUTE_LAST   = MinuteW'(59);

    localparam logic [1:0] BTN_HOUR   = 2'd0;
    localparam logic [1:0] BTN_MINUTE = 2'd1;
    localparam logic [1:0] BTN_SET    = 2'd2;
    localparam logic [1:0] BTN_MODE   = 2'd3;

    typedef struct packed {
        logic [1:0]     button;
        logic [MsW-1:0] now_ms;
    } t_dcas_in;

    typedef struct packed {
        logic               accepted;
        logic               alarm_mode;
        logic [HourW-1:0]   time_hour;
        logic [MinuteW-1:0] time_minute;
        logic [HourW-1:0]   alarm_hour;
        logic [MinuteW-1:0] alarm_minute;
        logic               write_time;
        logic               write_alarm;
        logic [HourW-1:0]   commit_hour;
        logic [MinuteW-1:0] commit_minute;
    } t_dcas_out;

    typedef struct packed {
        logic           we;
        logic [MsW-1:0] lockout_ms;
    } t_dcas_cfg;

    function automatic logic [HourW-1:0] step_hour(input logic [HourW-1:0] v);
        return (v >= HOUR_LAST) ? '0 : v + HourW'(1);
    endfunction

    function automatic logic [MinuteW-1:0] step_minute(input logic [MinuteW-1:0] v);
        return (v >= MINUTE_LAST) ? '0 : v + MinuteW'(1);
    endfunction

endpackage

// File: hdl/dcas_core.sv
// Setter state, lockout check and per-press update logic.
module dcas_core import dcas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_dcas_in  i_item,
    input  t_dcas_cfg i_cfg,
    output t_dcas_out o_res
);

    logic [MsW-1:0]     r_lockout;
    logic               r_mode;
    logic [HourW-1:0]   r_pend_hour;
    logic [MinuteW-1:0] r_pend_minute;
    logic [HourW-1:0]   r_alarm_hour;
    logic [MinuteW-1:0] r_alarm_minute;
    logic [MsW-1:0]     r_last_ms;

    logic               n_mode;
    logic [HourW-1:0]   n_pend_hour;
    logic [MinuteW-1:0] n_pend_minute;
    logic [HourW-1:0]   n_alarm_hour;
    logic [MinuteW-1:0] n_alarm_minute;
    logic               ok;
    logic [MsW-1:0]     delta;

    assign delta = i_item.now_ms - r_last_ms;
    assign ok    = (i_item.now_ms < r_last_ms) || (delta >= r_lockout);

    always_comb begin
        n_mode         = r_mode;
        n_pend_hour    = r_pend_hour;
        n_pend_minute  = r_pend_minute;
        n_alarm_hour   = r_alarm_hour;
        n_alarm_minute = r_alarm_minute;
        o_res          = '0;
        if (ok) begin
            unique case (i_item.button)
                BTN_HOUR: begin
                    if (!r_mode) n_pend_hour = step_hour(r_pend_hour);
                    else         n_alarm_hour = step_hour(r_alarm_hour);
                end
                BTN_MINUTE: begin
                    if (!r_mode) n_pend_minute = step_minute(r_pend_minute);
                    else         n_alarm_minute = step_minute(r_alarm_minute);
                end
                BTN_SET: begin
                    if (!r_mode) begin
                        o_res.write_time    = 1'b1;
                        o_res.commit_hour   = r_pend_hour;
                        o_res.commit_minute = r_pend_minute;
                        n_pend_hour         = '0;
                        n_pend_minute       = '0;
                    end else begin
                        o_res.write_alarm   = 1'b1;
                        o_res.commit_hour   = r_alarm_hour;
                        o_res.commit_minute = r_alarm_minute;
                    end
                end
                BTN_MODE: n_mode = ~r_mode;
                default:  n_mode = r_mode;
            endcase
        end
        o_res.accepted     = ok;
        o_res.alarm_mode   = n_mode;
        o_res.time_hour    = n_pend_hour;
        o_res.time_minute  = n_pend_minute;
        o_res.alarm_hour   = n_alarm_hour;
        o_res.alarm_minute = n_alarm_minute;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout      <= LOCKOUT_RESET;
            r_mode         <= 1'b0;
            r_pend_hour    <= '0;
            r_pend_minute  <= '0;
            r_alarm_hour   <= '0;
            r_alarm_minute <= '0;
            r_last_ms      <= '0;
        end else begin
            if (i_cfg.we) r_lockout <= i_cfg.lockout_ms;
            if (i_fire) begin
                r_mode         <= n_mode;
                r_pend_hour    <= n_pend_hour;
                r_pend_minute  <= n_pend_minute;
                r_alarm_hour   <= n_alarm_hour;
                r_alarm_minute <= n_alarm_minute;
                if (ok) r_last_ms <= i_item.now_ms;
            end
        end
    end

endmodule

// File: hdl/debounced_clock_alarm_setter_unit.sv
// Top level of the debounced clock and alarm setter: input and result registers.
//
//  channel | valid      | ready       | beat
//  --------+------------+-------------+------------------------
//  in      | i_in_valid | o_in_ready  | i_in_data  (t_dcas_in)
//  out     | o_out_valid| i_out_ready | o_out_data (t_dcas_out)
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_data (lockout_ms)
//
// A beat passes through the input register and leaves through the result
// register, one beat per cycle sustained while the result side is ready.
// The state update and lockout check sit between the two registers.
// Synchronous active-low reset restores lockout 500, clears the setter state and both valid flags.
// A stalled result register holds the input register; in stays ready while
// the input register is empty or moving. Config writes are always taken.
module debounced_clock_alarm_setter_unit import dcas_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  t_dcas_in       i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_dcas_out      o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [MsW-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_dcas_in  r_in;
    logic      r_out_valid;
    t_dcas_out r_out;
    logic      advance;
    t_dcas_out res;
    t_dcas_cfg cfg;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign cfg.we         = i_cfg_valid;
    assign cfg.lockout_ms = i_cfg_data;

    dcas_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in_data;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/dcas_checker.sv
// Port-level checks for the setter top level, bound to it.
module dcas_checker import dcas_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_dcas_out o_out_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.write_time && o_out_data.write_alarm)
            && ((!o_out_data.write_time && !o_out_data.write_alarm)
                || o_out_data.accepted))
        else $error("bad commit flags");

    a_commit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_time && !o_out_data.write_alarm
        |-> o_out_data.commit_hour == '0 && o_out_data.commit_minute == '0)
        else $error("commit fields set without a commit");

    a_time_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_time
        |-> !o_out_data.alarm_mode && o_out_data.time_hour == '0
            && o_out_data.time_minute == '0)
        else $error("time commit did not clear pending time");

endmodule

bind debounced_clock_alarm_setter_unit dcas_checker u_dcas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/sv/debounced_clock_alarm_setter_unit_tb.sv
// Testbench for debounced_clock_alarm_setter_unit: directed press table, then random press bursts.
module debounced_clock_alarm_setter_unit_tb import dcas_pkg::*;;

    localparam int HoursPerDay    = 24;
    localparam int MinutesPerHour = 60;
    localparam int HoldCycles     = 48;
    localparam int PhaseItems     = 72;
    localparam int MaxPrinted     = 40;

    typedef struct packed {
        logic [1:0]     button;
        logic [MsW-1:0] now_ms;
        logic           typed;
        t_dcas_out      want;
    } t_press_row;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    t_dcas_in       i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    t_dcas_out      o_out_data;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [MsW-1:0] i_cfg_data  = '0;

    // Typed-in expectation travels with the beat being offered.
    logic      note_typed = 1'b0;
    t_dcas_out note_want  = '0;

    // Shadow of the block state.
    logic               mode_alarm;
    logic [HourW-1:0]   edit_hour;
    logic [MinuteW-1:0] edit_minute;
    logic [HourW-1:0]   al_hour;
    logic [MinuteW-1:0] al_minute;
    logic [MsW-1:0]     last_ok_ms;
    logic [MsW-1:0]     lockout_now;
    t_dcas_out          pending_results[$];

    int errs       = 0;
    int n_press    = 0;
    int n_ok       = 0;
    int n_time_wr  = 0;
    int n_alarm_wr = 0;
    int n_wraps    = 0;
    int n_results  = 0;
    int n_lockouts = 0;

    bit             calm      = 1'b0;
    bit             stall_now = 1'b0;
    logic [MsW-1:0] stamp     = '0;
    int             lockout_set = 500;

    // Columns: button, stamp, typed-in, {acc, mode, th, tm, ah, am, wt, wa, ch, cm}
    t_press_row dir_rows [16] = '{
        {BTN_HOUR,   16'd0,     1'b1, 37'd0},
        {BTN_SET,    16'd499,   1'b1, 37'd0},
        {BTN_HOUR,   16'd500,   1'b1,
            {1'b1, 1'b0, 5'd1, 6'd0, 5'd0, 6'd0, 1'b0, 1'b0, 5'd0, 6'd0}},
        {BTN_MINUTE, 16'd1000,  1'b0, 37'd0},
        {BTN_MINUTE, 16'd1499,  1'b0, 37'd0},
        {BTN_SET,    16'd1500,  1'b1,
            {1'b1, 1'b0, 5'd0, 6'd0, 5'd0, 6'd0, 1'b1, 1'b0, 5'd1, 6'd1}},
        {BTN_MODE,   16'd2000,  1'b0, 37'd0},
        {BTN_HOUR,   16'd2500,  1'b0, 37'd0},
        {BTN_MINUTE, 16'd3000,  1'b0, 37'd0},
        {BTN_SET,    16'd3500,  1'b1,
            {1'b1, 1'b1, 5'd0, 6'd0, 5'd1, 6'd1, 1'b0, 1'b1, 5'd1, 6'd1}},
        {BTN_SET,    16'd3600,  1'b0, 37'd0},
        {BTN_MODE,   16'd100,   1'b0, 37'd0},
        {BTN_HOUR,   16'd65535, 1'b0, 37'd0},
        {BTN_MINUTE, 16'd0,     1'b0, 37'd0},
        {BTN_SET,    16'd65534, 1'b0, 37'd0},
        {BTN_HOUR,   16'd65535, 1'b0, 37'd0}
    };

    debounced_clock_alarm_setter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errs++;
        if (errs <= MaxPrinted) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    function automatic t_dcas_out apply_press(input t_dcas_in item);
        t_dcas_out r;
        int        nxt;
        r = '0;
        r.accepted = (item.now_ms < last_ok_ms) || ((item.now_ms - last_ok_ms) >= lockout_now);
        if (r.accepted) begin
            case (item.button)
                BTN_HOUR: begin
                    nxt = (mode_alarm ? int'(al_hour) : int'(edit_hour)) + 1;
                    if (nxt >= HoursPerDay) begin
                        nxt = 0;
                        n_wraps++;
                    end
                    if (mode_alarm) al_hour = HourW'(nxt);
                    else edit_hour = HourW'(nxt);
                end
                BTN_MINUTE: begin
                    nxt = (mode_alarm ? int'(al_minute) : int'(edit_minute)) + 1;
                    if (nxt >= MinutesPerHour) begin
                        nxt = 0;
                        n_wraps++;
                    end
                    if (mode_alarm) al_minute = MinuteW'(nxt);
                    else edit_minute = MinuteW'(nxt);
                end
                BTN_SET: begin
                    if (!mode_alarm) begin
                        r.write_time    = 1'b1;
                        r.commit_hour   = edit_hour;
                        r.commit_minute = edit_minute;
                        edit_hour       = '0;
                        edit_minute     = '0;
                    end else begin
                        r.write_alarm   = 1'b1;
                        r.commit_hour   = al_hour;
                        r.commit_minute = al_minute;
                    end
                end
                default: mode_alarm = ~mode_alarm;
            endcase
            last_ok_ms = item.now_ms;
        end
        r.alarm_mode   = mode_alarm;
        r.time_hour    = edit_hour;
        r.time_minute  = edit_minute;
        r.alarm_hour   = al_hour;
        r.alarm_minute = al_minute;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dcas_out want;
        string     bad;
        if (!i_rst_n) begin
            mode_alarm  = 1'b0;
            edit_hour   = '0;
            edit_minute = '0;
            al_hour     = '0;
            al_minute   = '0;
            last_ok_ms  = '0;
            lockout_now = LOCKOUT_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                lockout_now = i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing expected", o_out_data));
                end else begin
                    want = pending_results.pop_front();
                    bad  = "";
                    if (o_out_data.accepted !== want.accepted) bad = {bad, " accepted"};
                    if (o_out_data.alarm_mode !== want.alarm_mode) bad = {bad, " alarm_mode"};
                    if (o_out_data.time_hour !== want.time_hour) bad = {bad, " time_hour"};
                    if (o_out_data.time_minute !== want.time_minute) bad = {bad, " time_minute"};
                    if (o_out_data.alarm_hour !== want.alarm_hour) bad = {bad, " alarm_hour"};
                    if (o_out_data.alarm_minute !== want.alarm_minute) bad = {bad, " alarm_minute"};
                    if (o_out_data.write_time !== want.write_time) bad = {bad, " write_time"};
                    if (o_out_data.write_alarm !== want.write_alarm) bad = {bad, " write_alarm"};
                    if (o_out_data.commit_hour !== want.commit_hour) bad = {bad, " commit_hour"};
                    if (o_out_data.commit_minute !== want.commit_minute) begin
                        bad = {bad, " commit_minute"};
                    end
                    if (bad != "") begin
                        report_mismatch($sformatf("result %0d:%s differ, got %h want %h",
                                                  n_results, bad, o_out_data, want));
                    end
                    n_results++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = apply_press(i_in_data);
                n_press++;
                if (want.accepted) n_ok++;
                if (want.write_time) n_time_wr++;
                if (want.write_alarm) n_alarm_wr++;
                pending_results.push_back(note_typed ? note_want : want);
            end
        end
    end

    // Result side: random stall bursts, one long hold on request, none at the end.
    initial begin
        forever begin
            if (stall_now) begin
                stall_now = 1'b0;
                i_out_ready <= 1'b0;
                for (int k = 0; k < HoldCycles; k++) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic offer_press(input logic [1:0] btn, input logic [MsW-1:0] now,
                               input logic typed, input t_dcas_out want);
        i_in_valid <= 1'b1;
        i_in_data  <= {btn, now};
        note_typed <= typed;
        note_want  <= want;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Mostly clears the lockout; now and then lands inside it.
    function automatic logic [MsW-1:0] next_stamp();
        if ($urandom_range(0, 9) == 0) begin
            stamp = stamp + MsW'($urandom_range(0, (lockout_set > 0) ? lockout_set - 1 : 0));
        end else begin
            stamp = stamp + MsW'(lockout_set + $urandom_range(0, 300));
        end
        return stamp;
    endfunction

    task automatic run_press_bursts(input int count);
        int         sent;
        int         r;
        int         k;
        int         len;
        logic [1:0] btn;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                k   = $urandom_range(0, 9);
                btn = (k < 4) ? BTN_HOUR : (k < 8) ? BTN_MINUTE : (k < 9) ? BTN_SET : BTN_MODE;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 8);
                if (len > count - sent) len = count - sent;
                repeat (len) begin
                    offer_press(btn, next_stamp(), 1'b0, '0);
                    sent++;
                end
            end else if (r < 90) begin
                offer_press((r < 80) ? BTN_SET : BTN_MODE, next_stamp(), 1'b0, '0);
                sent++;
            end else begin
                stamp = MsW'($urandom_range(0, 65535));
                offer_press(2'($urandom_range(0, 3)), stamp, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_lockout(input logic [MsW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lockout_set = value;
        n_lockouts++;
    endtask

    initial begin
        int phase_lockouts [6];
        phase_lockouts = '{0, 65535, 1, $urandom_range(2, 65534), 500, $urandom_range(1, 2000)};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            offer_press(dir_rows[i].button, dir_rows[i].now_ms, dir_rows[i].typed,
                        dir_rows[i].want);
        end
        stamp = dir_rows[15].now_ms;

        foreach (phase_lockouts[p]) begin
            wait_drained();
            calm = (p == 5);
            write_lockout(MsW'(phase_lockouts[p]));
            // fill the pipe against a held-off result side
            if (p == 0) stall_now = 1'b1;
            run_press_bursts(PhaseItems);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d presses: %0d accepted, %0d time and %0d alarm commits, %0d wraps.",
                 n_press, n_ok, n_time_wr, n_alarm_wr, n_wraps);
        $display("Lockout written %0d times incl. 0 and 65535; %0d result beats checked.",
                 n_lockouts, n_results);
        if (errs == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
